// ===== sv/matq_pkg.sv =====
// Package for the multi-alarm timer queue: command and result codes,
// the state machine type and default sizes. No dependencies.
package matq_pkg;

    localparam int NUM_OWNERS_DEF       = 8;
    localparam int ALARMS_PER_OWNER_DEF = 4;
    localparam int MAX_RESULTS          = 32;

    typedef enum logic [2:0] {
        CMD_ARM     = 3'd0,
        CMD_DISARM  = 3'd1,
        CMD_QUERY   = 3'd2,
        CMD_SHIFT   = 3'd3,
        CMD_PROCESS = 3'd4
    } cmd_t;

    typedef enum logic [2:0] {
        KIND_DONE  = 3'd0,
        KIND_LEFT  = 3'd1,
        KIND_FIRED = 3'd2,
        KIND_NONE  = 3'd3,
        KIND_ERROR = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_SCAN,
        ST_PICK,
        ST_EMIT
    } state_t;

    // Clamp a 34-bit signed sum to 0..2^32-1.
    function automatic logic [31:0] clamp32(input logic signed [33:0] v);
        logic [31:0] r;
        if (v[33])
            r = '0;
        else if (v[32])
            r = '1;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== sv/matq_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module matq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/multi_alarm_timer_queue.sv =====
// Multi-alarm timer queue top level. Depends on matq_pkg and matq_ram.
// Expiry and stamp live in one RAM; slot valid bits are flip-flops.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | command owner alarm_index offset_ticks now_ticks
//  out     | out_valid | out_stall | kind fired_owner fired_index time_left last
//
// Slot address is {owner, alarm_index}: NUM_OWNERS*4 RAM entries.
// Slot command: result registered after acceptance (read, execute);
// the next command is taken the cycle after the result is taken.
// Process: per fired alarm one scan of all NUM_OWNERS*4 slots, one pick and one
// emit; the scan also counts expired alarms so the final result carries last.
// Reset clears valid bits and stamp counter.
// A stalled output holds; the next command waits until the result is taken.
module multi_alarm_timer_queue #(
    parameter int NUM_OWNERS       = matq_pkg::NUM_OWNERS_DEF,
    parameter int ALARMS_PER_OWNER = matq_pkg::ALARMS_PER_OWNER_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [2:0]         owner,
    input  logic [1:0]         alarm_index,
    input  logic signed [31:0] offset_ticks,
    input  logic [31:0]        now_ticks,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         kind,
    output logic [2:0]         fired_owner,
    output logic [1:0]         fired_index,
    output logic signed [32:0] time_left,
    output logic               last
);

    localparam int NSLOTS = NUM_OWNERS * 4;
    localparam int SW     = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int CW     = $clog2(NSLOTS + 1);
    localparam int RW     = $clog2(matq_pkg::MAX_RESULTS + 1);

    matq_pkg::state_t state_reg, state_next;

    logic [NSLOTS-1:0]  valid_reg, valid_next;
    logic [31:0]        stamp_reg, stamp_next;
    logic [2:0]         cmd_reg;
    logic [2:0]         own_reg;
    logic [1:0]         idx_reg;
    logic signed [31:0] off_reg;
    logic [31:0]        now_reg;
    logic               addr_ok_reg;
    logic [SW-1:0]      slot_reg;

    // scan state
    logic [CW-1:0]      scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]      exp_cnt_reg, exp_cnt_next;
    logic               rd_v_reg;
    logic [SW-1:0]      rd_slot_reg;
    logic               best_v_reg, best_v_next;
    logic [SW-1:0]      best_slot_reg, best_slot_next;
    logic [31:0]        best_exp_reg, best_exp_next;
    logic [31:0]        best_stp_reg, best_stp_next;
    logic [RW-1:0]      nres_reg, nres_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         kind_reg, kind_next;
    logic [2:0]         fo_reg, fo_next;
    logic [1:0]         fi_reg, fi_next;
    logic signed [32:0] tl_reg, tl_next;
    logic               last_reg, last_next;

    logic               we;
    logic [SW-1:0]      waddr, raddr;
    logic [63:0]        wdata, rdata;
    logic [31:0]        r_exp, r_stp;
    logic               in_acc, out_free;
    logic               emit_last;

    assign r_exp    = rdata[63:32];
    assign r_stp    = rdata[31:0];
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != matq_pkg::ST_IDLE) || out_valid_reg;

    // picked alarm is the only expired one left, or the result cap is reached
    assign emit_last = (exp_cnt_reg == CW'(1)) ||
                       (nres_reg + 1'b1 == RW'(matq_pkg::MAX_RESULTS));

    matq_ram #(.WIDTH(64), .DEPTH(NSLOTS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // capture command
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg     <= command;
            own_reg     <= owner;
            idx_reg     <= alarm_index;
            off_reg     <= offset_ticks;
            now_reg     <= now_ticks;
            addr_ok_reg <= (32'(owner) < NUM_OWNERS) && (32'(alarm_index) < ALARMS_PER_OWNER);
            slot_reg    <= SW'({owner, alarm_index});
        end
    end

    // scan pipeline tag: slot whose data appears on rdata this cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg    <= 1'b0;
            rd_slot_reg <= '0;
        end
        else
        begin
            rd_v_reg    <= (state_reg == matq_pkg::ST_SCAN) && (scan_cnt_reg < CW'(NSLOTS));
            rd_slot_reg <= raddr;
        end
    end

    always_comb
    begin
        raddr = slot_reg;
        if (state_reg == matq_pkg::ST_SCAN)
            raddr = SW'(scan_cnt_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            matq_pkg::ST_IDLE:
                if (in_acc)
                    state_next = (command == matq_pkg::CMD_PROCESS) ?
                                 matq_pkg::ST_SCAN : matq_pkg::ST_READ;
            matq_pkg::ST_READ:
                state_next = matq_pkg::ST_EXEC;
            matq_pkg::ST_EXEC:
                if (out_free)
                    state_next = matq_pkg::ST_IDLE;
            matq_pkg::ST_SCAN:
                if (scan_cnt_reg == CW'(NSLOTS) && !rd_v_reg)
                    state_next = matq_pkg::ST_PICK;
            matq_pkg::ST_PICK:
                state_next = matq_pkg::ST_EMIT;
            matq_pkg::ST_EMIT:
                if (out_free)
                    state_next = (best_v_reg && !emit_last) ?
                                 matq_pkg::ST_SCAN : matq_pkg::ST_IDLE;
            default:
                state_next = matq_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        logic signed [33:0] sum;
        logic [31:0]        nt;
        logic               cand, better;
        valid_next     = valid_reg;
        stamp_next     = stamp_reg;
        scan_cnt_next  = scan_cnt_reg;
        exp_cnt_next   = exp_cnt_reg;
        best_v_next    = best_v_reg;
        best_slot_next = best_slot_reg;
        best_exp_next  = best_exp_reg;
        best_stp_next  = best_stp_reg;
        nres_next      = nres_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        fo_next        = fo_reg;
        fi_next        = fi_reg;
        tl_next        = tl_reg;
        last_next      = last_reg;
        we             = 1'b0;
        waddr          = slot_reg;
        wdata          = {now_reg, stamp_reg};
        sum            = '0;
        nt             = '0;
        cand           = 1'b0;
        better         = 1'b0;
        case (state_reg)
            matq_pkg::ST_IDLE:
            begin
                scan_cnt_next = '0;
                exp_cnt_next  = '0;
                best_v_next   = 1'b0;
                nres_next     = '0;
            end
            matq_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    fo_next        = own_reg;
                    fi_next        = idx_reg;
                    tl_next        = '0;
                    last_next      = 1'b1;
                    kind_next      = matq_pkg::KIND_ERROR;
                    if (cmd_reg == matq_pkg::CMD_ARM && addr_ok_reg)
                    begin
                        sum        = 34'(signed'({2'b00, now_reg})) + 34'(off_reg);
                        we         = 1'b1;
                        wdata      = {matq_pkg::clamp32(sum), stamp_reg};
                        stamp_next = stamp_reg + 32'd1;
                        valid_next[slot_reg] = 1'b1;
                        kind_next  = matq_pkg::KIND_DONE;
                    end
                    else if (addr_ok_reg && cmd_reg < matq_pkg::CMD_PROCESS &&
                             valid_reg[slot_reg])
                    begin
                        if (cmd_reg == matq_pkg::CMD_DISARM)
                        begin
                            valid_next[slot_reg] = 1'b0;
                            kind_next = matq_pkg::KIND_DONE;
                        end
                        else if (cmd_reg == matq_pkg::CMD_QUERY)
                        begin
                            kind_next = matq_pkg::KIND_LEFT;
                            tl_next   = $signed({1'b0, r_exp}) - $signed({1'b0, now_reg});
                        end
                        else
                        begin
                            sum = 34'(signed'({2'b00, r_exp})) + 34'(off_reg);
                            nt  = matq_pkg::clamp32(sum);
                            if (nt > now_reg)
                            begin
                                we         = 1'b1;
                                wdata      = {nt, stamp_reg};
                                stamp_next = stamp_reg + 32'd1;
                                kind_next  = matq_pkg::KIND_DONE;
                            end
                        end
                    end
                end
            end
            matq_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg < CW'(NSLOTS))
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                if (rd_v_reg)
                begin
                    cand   = valid_reg[rd_slot_reg] && (r_exp <= now_reg);
                    better = !best_v_reg || (r_exp < best_exp_reg) ||
                             (r_exp == best_exp_reg && r_stp < best_stp_reg);
                    if (cand)
                        exp_cnt_next = exp_cnt_reg + 1'b1;
                    if (cand && better)
                    begin
                        best_v_next    = 1'b1;
                        best_slot_next = rd_slot_reg;
                        best_exp_next  = r_exp;
                        best_stp_next  = r_stp;
                    end
                end
            end
            matq_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    tl_next        = '0;
                    scan_cnt_next  = '0;
                    exp_cnt_next   = '0;
                    best_v_next    = 1'b0;
                    if (best_v_reg)
                    begin
                        valid_next[best_slot_reg] = 1'b0;
                        kind_next = matq_pkg::KIND_FIRED;
                        fo_next   = 3'(best_slot_reg >> 2);
                        fi_next   = best_slot_reg[1:0];
                        nres_next = nres_reg + 1'b1;
                        last_next = emit_last;
                    end
                    else
                    begin
                        kind_next = matq_pkg::KIND_NONE;
                        fo_next   = '0;
                        fi_next   = '0;
                        last_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= matq_pkg::ST_IDLE;
            valid_reg     <= '0;
            stamp_reg     <= '0;
            scan_cnt_reg  <= '0;
            exp_cnt_reg   <= '0;
            best_v_reg    <= 1'b0;
            nres_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            stamp_reg     <= stamp_next;
            scan_cnt_reg  <= scan_cnt_next;
            exp_cnt_reg   <= exp_cnt_next;
            best_v_reg    <= best_v_next;
            nres_reg      <= nres_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_slot_reg <= best_slot_next;
        best_exp_reg  <= best_exp_next;
        best_stp_reg  <= best_stp_next;
        kind_reg      <= kind_next;
        fo_reg        <= fo_next;
        fi_reg        <= fi_next;
        tl_reg        <= tl_next;
        last_reg      <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign fired_owner = fo_reg;
    assign fired_index = fi_reg;
    assign time_left   = tl_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != matq_pkg::ST_IDLE) |-> in_stall)
        else $error("command accepted while busy");
    a_pick_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == matq_pkg::ST_EMIT && best_v_reg) |-> (exp_cnt_reg != '0))
        else $error("picked alarm not counted as expired");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg && $stable(kind_reg))
        else $error("stalled transaction changed");
    a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
        (stamp_reg != $past(stamp_reg)) |-> $past(we))
        else $error("stamp moved without a write");
`endif

endmodule

// ===== test/tb_multi_alarm_timer_queue.sv =====
// Testbench for multi_alarm_timer_queue: directed and random commands, results
// predicted by an in-bench model of the alarm slots. Depends on matq_pkg and the RTL.
module tb_multi_alarm_timer_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = matq_pkg::NUM_OWNERS_DEF * matq_pkg::ALARMS_PER_OWNER_DEF;
    localparam int WATCHDOG = 200000;

    typedef struct packed {
        matq_pkg::kind_t    kind;
        logic [2:0]         own;
        logic [1:0]         idx;
        logic signed [32:0] left;
        logic               last;
    } alarm_result_t;

    int n_errors = 0;

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    class alarm_scoreboard;
        bit          armed[NSLOT];
        logic [31:0] expiry[NSLOT];
        logic [31:0] stamp[NSLOT];
        logic [31:0] stamp_next = '0;
        alarm_result_t pending[$];

        function void add(matq_pkg::kind_t k, logic [2:0] o, logic [1:0] i,
                          logic signed [32:0] l, logic la);
            alarm_result_t r;
            r.kind = k; r.own = o; r.idx = i; r.left = l; r.last = la;
            pending.push_back(r);
        endfunction

        function logic [31:0] sat(input longint v);
            if (v < 0) return 32'd0;
            if (v > 64'hFFFFFFFF) return 32'hFFFFFFFF;
            return v[31:0];
        endfunction

        function void note_command(logic [2:0] cmd, logic [2:0] o, logic [1:0] i,
                                   logic signed [31:0] off, logic [31:0] now);
            int s, n, best;
            logic [31:0] nt;
            s = o * matq_pkg::ALARMS_PER_OWNER_DEF + i;
            if (cmd == matq_pkg::CMD_PROCESS) begin
                n = 0;
                while (n < matq_pkg::MAX_RESULTS) begin
                    best = -1;
                    for (int j = 0; j < NSLOT; j++)
                        if (armed[j] && expiry[j] <= now)
                            if (best < 0 || expiry[j] < expiry[best] ||
                                (expiry[j] == expiry[best] && stamp[j] < stamp[best]))
                                best = j;
                    if (best < 0) break;
                    armed[best] = 0;
                    add(matq_pkg::KIND_FIRED, 3'(best / matq_pkg::ALARMS_PER_OWNER_DEF),
                        2'(best % matq_pkg::ALARMS_PER_OWNER_DEF), 0, 0);
                    n++;
                end
                if (n == 0) add(matq_pkg::KIND_NONE, 0, 0, 0, 1);
                else pending[$].last = 1;
            end else if (cmd > matq_pkg::CMD_PROCESS) begin
                add(matq_pkg::KIND_ERROR, o, i, 0, 1);
            end else if (cmd == matq_pkg::CMD_ARM) begin
                expiry[s] = sat(longint'(now) + longint'(off));
                stamp[s] = stamp_next++;
                armed[s] = 1;
                add(matq_pkg::KIND_DONE, o, i, 0, 1);
            end else if (!armed[s]) begin
                add(matq_pkg::KIND_ERROR, o, i, 0, 1);
            end else if (cmd == matq_pkg::CMD_DISARM) begin
                armed[s] = 0;
                add(matq_pkg::KIND_DONE, o, i, 0, 1);
            end else if (cmd == matq_pkg::CMD_QUERY) begin
                add(matq_pkg::KIND_LEFT, o, i, 33'(longint'(expiry[s]) - longint'(now)), 1);
            end else begin
                nt = sat(longint'(expiry[s]) + longint'(off));
                if (nt <= now) add(matq_pkg::KIND_ERROR, o, i, 0, 1);
                else begin
                    expiry[s] = nt;
                    stamp[s] = stamp_next++;
                    add(matq_pkg::KIND_DONE, o, i, 0, 1);
                end
            end
        endfunction

        task check_result(alarm_result_t got);
            alarm_result_t exp;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind %0d", got.kind));
                return;
            end
            exp = pending.pop_front();
            if (got.kind !== exp.kind)
                report_mismatch($sformatf("kind %0d exp %0d", got.kind, exp.kind));
            if (got.own !== exp.own)
                report_mismatch($sformatf("owner %0d exp %0d", got.own, exp.own));
            if (got.idx !== exp.idx)
                report_mismatch($sformatf("index %0d exp %0d", got.idx, exp.idx));
            if (got.left !== exp.left)
                report_mismatch($sformatf("time_left %0d exp %0d", got.left, exp.left));
            if (got.last !== exp.last)
                report_mismatch($sformatf("last %0b exp %0b", got.last, exp.last));
        endtask
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_stall, out_valid, out_stall = 0;
    logic [2:0] command = 0, owner = 0;
    logic [1:0] alarm_index = 0;
    logic signed [31:0] offset_ticks = 0;
    logic [31:0] now_ticks = 0;
    logic [2:0] kind, fired_owner;
    logic [1:0] fired_index;
    logic signed [32:0] time_left;
    logic last;

    alarm_scoreboard sb = new();
    bit quiet = 0;      // no idling in the final stretch
    int idle_cycles = 0;
    logic [31:0] clock_now = 1000;

    multi_alarm_timer_queue uut (.*);

    initial forever #4 clk = ~clk;

    // receiver: random stall bursts, check on acceptance
    initial begin
        int burst;
        burst = 0;
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall) begin
                sb.check_result({matq_pkg::kind_t'(kind), fired_owner, fired_index,
                                 time_left, last});
            end
            if (burst > 0) burst--;
            else if (!quiet && $urandom_range(0, 7) == 0) burst = $urandom_range(1, 12);
            out_stall <= (burst > 0);
        end
    end

    initial begin
        forever begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG) begin
                $display("FAIL multi_alarm_timer_queue");
                $finish;
            end
        end
    end

    // valid stays high between back-to-back commands unless a random gap is drawn; the caller drops it
    task automatic send_command(input logic [2:0] cmd, input logic [2:0] o,
                                input logic [1:0] i, input logic [31:0] off,
                                input logic [31:0] now);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1;
        command <= cmd; owner <= o; alarm_index <= i;
        offset_ticks <= off; now_ticks <= now;
        do @(posedge clk); while (in_stall);
        sb.note_command(cmd, o, i, off, now);
    endtask

    task automatic drain_results();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    task automatic random_command();
        int r;
        logic [31:0] off;
        logic [2:0] o;
        logic [1:0] i;
        r = $urandom_range(0, 99);
        o = 3'($urandom_range(0, 7));
        i = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: off = $urandom;
            1: off = $urandom_range(0, 200);
            2: off = -$urandom_range(0, 200);
            default: off = $urandom_range(0, 40);
        endcase
        if ($urandom_range(0, 3) == 0) clock_now = $urandom;
        else clock_now += $urandom_range(0, 30);
        if (r < 35) send_command(matq_pkg::CMD_ARM, o, i, off, clock_now);
        else if (r < 45) send_command(matq_pkg::CMD_DISARM, o, i, off, clock_now);
        else if (r < 60) send_command(matq_pkg::CMD_QUERY, o, i, off, clock_now);
        else if (r < 75) send_command(matq_pkg::CMD_SHIFT, o, i, off, clock_now);
        else if (r < 97) send_command(matq_pkg::CMD_PROCESS, o, i, off, clock_now);
        else send_command(3'($urandom_range(5, 7)), o, i, off, clock_now);
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: empty process, unarmed errors, saturation, ties, overdue query
        send_command(matq_pkg::CMD_PROCESS, 0, 0, 0, 0);
        send_command(matq_pkg::CMD_QUERY, 7, 3, 0, 5);
        send_command(matq_pkg::CMD_DISARM, 0, 0, 0, 5);
        send_command(matq_pkg::CMD_SHIFT, 3, 2, 10, 5);
        send_command(matq_pkg::CMD_ARM, 7, 3, 32'h7FFFFFFF, 32'hFFFFFFF0);
        send_command(matq_pkg::CMD_QUERY, 7, 3, 0, 0);
        send_command(matq_pkg::CMD_ARM, 0, 0, 32'h80000000, 32'd10);
        send_command(matq_pkg::CMD_QUERY, 0, 0, 0, 32'hFFFFFFFF);
        send_command(matq_pkg::CMD_ARM, 1, 1, 20, 100);
        send_command(matq_pkg::CMD_ARM, 2, 0, 20, 100);
        send_command(matq_pkg::CMD_ARM, 1, 1, 20, 100);   // re-arm moves behind
        send_command(matq_pkg::CMD_SHIFT, 2, 0, -50, 110); // not after now
        send_command(matq_pkg::CMD_SHIFT, 2, 0, 32'h80000000, 110);
        send_command(matq_pkg::CMD_SHIFT, 2, 0, 5, 110);
        send_command(matq_pkg::CMD_SHIFT, 7, 3, 32'h7FFFFFFF, 0);
        send_command(5, 4, 2, 0, 0);
        send_command(7, 3, 1, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_command(matq_pkg::CMD_PROCESS, 0, 0, 0, 200);
        send_command(matq_pkg::CMD_DISARM, 7, 3, 0, 0);
        for (int s = 0; s < NSLOT; s++)
            send_command(matq_pkg::CMD_ARM, 3'(s / 4), 2'(s % 4), 3, 300);
        send_command(matq_pkg::CMD_PROCESS, 6, 1, 0, 400);
        // pause until every expected result is back
        drain_results();
        for (int n = 0; n < 317; n++) begin
            if (n == 270) quiet = 1;
            random_command();
        end
        send_command(matq_pkg::CMD_PROCESS, 0, 0, 0, 32'hFFFFFFFF);
        drain_results();
        repeat (50) @(posedge clk);
        if (n_errors == 0 && sb.pending.size() == 0)
            $display("PASS multi_alarm_timer_queue");
        else
            $display("FAIL multi_alarm_timer_queue");
        $finish;
    end
endmodule

// ===== files.f =====
sv/matq_pkg.sv
sv/matq_ram.sv
sv/multi_alarm_timer_queue.sv
test/tb_multi_alarm_timer_queue.sv
